// ===== sv/pptu_pkg.sv =====
// Package for the polar point transform unit: widths, op codes, CORDIC
// arctangent table and gain constant. No dependencies.
package pptu_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int ATAN_COUNT   = 31;
  localparam int NSTEPS       = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
  localparam int STEP_W       = $clog2(ATAN_COUNT + 1);
  localparam int XW           = 36;

  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

  localparam logic [2:0] OP_SET_CART  = 3'd0;
  localparam logic [2:0] OP_SET_POLAR = 3'd1;
  localparam logic [2:0] OP_OFFSET    = 3'd2;
  localparam logic [2:0] OP_SCALE     = 3'd3;
  localparam logic [2:0] OP_ADD_RAD   = 3'd4;
  localparam logic [2:0] OP_ROTATE    = 3'd5;
  localparam logic [2:0] OP_READ      = 3'd6;
  localparam logic [2:0] OP_SPARE     = 3'd7;

  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0:  t = 32'h20000000;  5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;  5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;  5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;  5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;  5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;  5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;  5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;  5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;  5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;  5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;  5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;  5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;  5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;  5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003;  5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [XW+1:0] v);
    if (v > $signed({{(XW-30){1'b0}}, 32'h7FFFFFFF})) return 32'h7FFFFFFF;
    if (v < -$signed({{(XW-30){1'b0}}, 32'h80000000})) return 32'h80000000;
    return v[31:0];
  endfunction

endpackage

// ===== sv/pptu_cordic.sv =====
// Shared CORDIC micro-rotation step: one add/subtract triple with shifts.
// Depends on pptu_pkg.
module pptu_cordic import pptu_pkg::*; (
  input  logic signed [XW-1:0] x,
  input  logic signed [XW-1:0] y,
  input  logic        [31:0]   z,
  input  logic        [STEP_W-1:0] step,
  input  logic                 vectoring,
  output logic signed [XW-1:0] x_new,
  output logic signed [XW-1:0] y_new,
  output logic        [31:0]   z_new
);
  logic signed [XW-1:0] dx, dy;
  logic pos;

  // choose direction from angle residue or from y sign
  always_comb begin
    dx = y >>> step;
    dy = x >>> step;
    pos = vectoring ? !y[XW-1] : !z[31];
    if (pos ^ vectoring) begin
      x_new = x - dx; y_new = y + dy; z_new = z - atan_turn(step);
    end else begin
      x_new = x + dx; y_new = y - dy; z_new = z + atan_turn(step);
    end
    if (vectoring && !pos) begin
      x_new = x - dx; y_new = y + dy; z_new = z - atan_turn(step);
    end else if (vectoring) begin
      x_new = x + dx; y_new = y - dy; z_new = z + atan_turn(step);
    end
  end
endmodule

// ===== sv/polar_point_transform_unit_core.sv =====
// Top level of the polar point transform unit: sequencer, state and one
// shared multiplier around the CORDIC step. Depends on pptu_pkg, pptu_cordic.
//
// A read, rotate, add radius or set polar runs one CORDIC rotation pass (one
// step per cycle, CORDIC_STEPS steps) plus the gain, fold and output states;
// set cartesian first runs a vectoring pass with a gain split into high and
// low parts; offset and scale both run a rotation pass, a vectoring pass and
// a final rotation pass. All passes use the single CORDIC step unit, and the
// single 32x32 multiplier serves gain and scaling. The block is not ready
// while a transaction is in work; the result waits in an output register,
// so the next transaction may start while it waits, and a second result
// holds in the last step until the first is taken.
module polar_point_transform_unit_core import pptu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: op[2:0], operand_a[34:3], operand_b[66:35], zero fill to 72
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: x_coord[31:0], y_coord[63:32], radius_out[95:64], angle_out[127:96]
  output logic [127:0] m_tdata
);
  localparam logic [3:0] S_IDLE = 4'd0, S_R_GAIN = 4'd1, S_R_FOLD = 4'd2,
    S_R_ITER = 4'd3, S_MULX = 4'd4, S_MULY = 4'd5, S_V_START = 4'd6,
    S_V_ITER = 4'd7, S_V_GAIN = 4'd8, S_OUT = 4'd9, S_V_DONE = 4'd10,
    S_V_GAIN_LO = 4'd11;

  logic [3:0] state;
  logic       final_pass;
  logic [2:0] op;
  logic signed [31:0] a, b, radius, cx, cy;
  logic [31:0] heading, z;
  logic signed [XW-1:0] x, y, x_new, y_new;
  logic [31:0] z_new;
  logic [STEP_W-1:0] step;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] gain_prod;
  logic signed [63:0] gain_acc;
  logic signed [63:0] gain_sum;

  pptu_cordic u_cordic (
    .x(x), .y(y), .z(z), .step(step), .vectoring(state == S_V_ITER),
    .x_new(x_new), .y_new(y_new), .z_new(z_new)
  );

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_MULX:  begin mul_a = cx; mul_b = a; end
      S_MULY:  begin mul_a = cy; mul_b = b; end
      S_V_GAIN: begin mul_a = {{(44-XW){x[XW-1]}}, x[XW-1:16]}; mul_b = GAIN_Q30; end
      S_V_GAIN_LO: begin mul_a = {16'b0, x[15:0]}; mul_b = GAIN_Q30; end
      default: begin mul_a = radius; mul_b = GAIN_Q30; end
    endcase
    prod = mul_a * mul_b;
    gain_prod = prod >>> 30;
    gain_sum = gain_acc + prod;
  end

  assign s_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; m_tvalid <= 1'b0; radius <= '0; heading <= '0;
      final_pass <= 1'b0;
    end else begin
      // raise the result when it is stored, drop it once taken
      if (state == S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          op <= s_tdata[2:0];
          a  <= s_tdata[34:3];
          b  <= s_tdata[66:35];
          unique case (s_tdata[2:0])
            OP_SET_CART: begin
              cx <= s_tdata[34:3]; cy <= s_tdata[66:35];
              final_pass <= 1'b1; state <= S_V_START;
            end
            OP_SET_POLAR: begin
              radius <= s_tdata[34:3]; heading <= s_tdata[66:35];
              final_pass <= 1'b1; state <= S_R_GAIN;
            end
            OP_ADD_RAD: begin
              radius <= sat32({{(XW-30){s_tdata[34]}}, s_tdata[34:3]} +
                              {{(XW-30){radius[31]}}, radius});
              final_pass <= 1'b1; state <= S_R_GAIN;
            end
            OP_ROTATE: begin
              heading <= heading + s_tdata[34:3];
              final_pass <= 1'b1; state <= S_R_GAIN;
            end
            OP_OFFSET, OP_SCALE: begin
              final_pass <= 1'b0; state <= S_R_GAIN;
            end
            OP_READ, OP_SPARE: begin final_pass <= 1'b1; state <= S_R_GAIN; end
          endcase
        end
        S_R_GAIN: begin
          x <= gain_prod[XW-1:0]; y <= '0; z <= heading; state <= S_R_FOLD;
        end
        S_R_FOLD: begin
          // fold the back half-plane onto the front
          if ((heading + 32'h40000000) >= 32'h80000000) begin
            x <= -x; z <= heading + 32'h80000000;
          end
          step <= '0; state <= S_R_ITER;
        end
        S_R_ITER: begin
          x <= x_new; y <= y_new; z <= z_new; step <= step + 1'b1;
          if (step == STEP_W'(NSTEPS - 1)) begin
            cx <= sat32({{2{x_new[XW-1]}}, x_new});
            cy <= sat32({{2{y_new[XW-1]}}, y_new});
            if (final_pass) state <= S_OUT;
            else if (op == OP_SCALE) state <= S_MULX;
            else state <= S_V_DONE;
          end
        end
        S_V_DONE: begin
          cx <= sat32({{(XW-30){cx[31]}}, cx} + {{(XW-30){a[31]}}, a});
          cy <= sat32({{(XW-30){cy[31]}}, cy} + {{(XW-30){b[31]}}, b});
          final_pass <= 1'b1; state <= S_V_START;
        end
        S_MULX: begin
          cx <= sat32(XW'(prod >>> FRAC_BITS) == (prod >>> FRAC_BITS) ?
                      {{2{prod[FRAC_BITS+XW-1]}}, prod[FRAC_BITS +: XW]} :
                      (prod[63] ? {2'b11, 1'b1, {(XW-1){1'b0}}} :
                                  {2'b00, 1'b0, {(XW-1){1'b1}}}));
          state <= S_MULY;
        end
        S_MULY: begin
          cy <= sat32(XW'(prod >>> FRAC_BITS) == (prod >>> FRAC_BITS) ?
                      {{2{prod[FRAC_BITS+XW-1]}}, prod[FRAC_BITS +: XW]} :
                      (prod[63] ? {2'b11, 1'b1, {(XW-1){1'b0}}} :
                                  {2'b00, 1'b0, {(XW-1){1'b1}}}));
          final_pass <= 1'b1; state <= S_V_START;
        end
        S_V_START: begin
          step <= '0;
          if (cx == 0 && cy == 0) begin
            radius <= '0; heading <= '0; state <= S_R_GAIN;
          end else if (cx[31]) begin
            x <= -{{(XW-32){cx[31]}}, cx}; y <= -{{(XW-32){cy[31]}}, cy};
            z <= 32'h80000000; state <= S_V_ITER;
          end else begin
            x <= {{(XW-32){cx[31]}}, cx}; y <= {{(XW-32){cy[31]}}, cy};
            z <= '0; state <= S_V_ITER;
          end
        end
        S_V_ITER: begin
          x <= x_new; y <= y_new; z <= z_new; step <= step + 1'b1;
          if (step == STEP_W'(NSTEPS - 1)) state <= S_V_GAIN;
        end
        S_V_GAIN: begin
          // upper bits of the magnitude times the gain, aligned to the low part
          gain_acc <= prod <<< 16;
          state <= S_V_GAIN_LO;
        end
        S_V_GAIN_LO: begin
          // add the low 16 bits of the magnitude times the gain
          radius <= sat32({{4{gain_sum[63]}}, gain_sum[63:30]});
          heading <= z; state <= S_R_GAIN;
        end
        S_OUT: if (!m_tvalid || m_tready) begin
          m_tdata <= {heading, radius, cy, cx};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result never raised while work is still in flight
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> state == S_IDLE) else $error("result raised mid-work");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE) else $error("ready while busy");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_R_ITER || state == S_V_ITER) |-> step < STEP_W'(NSTEPS))
    else $error("step out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("waiting result changed");
endmodule

// ===== tb/polar_point_transform_unit_core_test.sv =====
// Testbench for polar_point_transform_unit_core: drives op/operand transactions,
// predicts x, y, radius and heading with a bit-exact CORDIC model. Depends on pptu_pkg and the core.
module polar_point_transform_unit_core_test;
  import pptu_pkg::*;

  typedef struct packed {
    logic [31:0] ang;
    logic [31:0] rad;
    logic [31:0] y;
    logic [31:0] x;
  } point_t;

  localparam int STALL_LIMIT = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;

  // Predicted point state
  longint       pt_radius;
  logic [31:0]  pt_heading;
  point_t       expected_points[$];
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           recv_hold = 1'b0;
  int           quiet_cycles = 0;

  polar_point_transform_unit_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sign32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint gain_comp(longint v);
    return shr_floor(v * longint'(GAIN_Q30), 30);
  endfunction

  // Rotation pass: stored polar point to cartesian
  task automatic polar_to_xy(output longint xo, output longint yo);
    longint x, y, z, dx, dy;
    logic [31:0] zu;
    x = gain_comp(pt_radius);
    y = 0;
    zu = pt_heading;
    if (zu + 32'h40000000 >= 32'h80000000) begin
      x = -x;
      zu = zu + 32'h80000000;
    end
    z = sign32(zu);
    for (int i = 0; i < NSTEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(STEP_W'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(STEP_W'(i)));
      end
    end
    xo = clamp32(x);
    yo = clamp32(y);
  endtask

  // Vectoring pass: cartesian to stored polar point
  task automatic xy_to_polar(input longint xi, input longint yi);
    longint x, y, dx, dy;
    logic [31:0] z;
    x = xi; y = yi; z = '0;
    if (x == 0 && y == 0) begin
      pt_radius = 0;
      pt_heading = '0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < NSTEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z = z + atan_turn(STEP_W'(i));
      end else begin
        x -= dx; y += dy; z = z - atan_turn(STEP_W'(i));
      end
    end
    pt_radius = clamp32(gain_comp(x));
    pt_heading = z;
  endtask

  task automatic predict_point(input logic [2:0] op, input logic [31:0] a,
                               input logic [31:0] b);
    longint x, y, sa, sb;
    point_t p;
    sa = sign32(a);
    sb = sign32(b);
    case (op)
      OP_SET_CART: xy_to_polar(sa, sb);
      OP_SET_POLAR: begin
        pt_radius = sa;
        pt_heading = b;
      end
      OP_OFFSET: begin
        polar_to_xy(x, y);
        xy_to_polar(clamp32(x + sa), clamp32(y + sb));
      end
      OP_SCALE: begin
        polar_to_xy(x, y);
        xy_to_polar(clamp32(shr_floor(x * sa, FRAC_BITS)),
                    clamp32(shr_floor(y * sb, FRAC_BITS)));
      end
      OP_ADD_RAD: pt_radius = clamp32(pt_radius + sa);
      OP_ROTATE: pt_heading = pt_heading + a;
      default: ;
    endcase
    polar_to_xy(x, y);
    p.x = x[31:0];
    p.y = y[31:0];
    p.rad = pt_radius[31:0];
    p.ang = pt_heading;
    expected_points.push_back(p);
  endtask

  // Offer one transaction and wait for it to be accepted
  task automatic send_op(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_tdata = {5'b0, b, a, op};
    s_tvalid = 1'b1;
    predict_point(op, a, b);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Receiver readiness
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result against the oldest prediction
  always @(posedge clk) begin
    point_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_points.size() == 0) begin
        $error("result with no transaction pending: %h", m_tdata);
        fail_count++;
      end else begin
        want = expected_points.pop_front();
        if (got.x != want.x) begin
          $error("x_coord expected %h actual %h", want.x, got.x); fail_count++;
        end
        if (got.y != want.y) begin
          $error("y_coord expected %h actual %h", want.y, got.y); fail_count++;
        end
        if (got.rad != want.rad) begin
          $error("radius_out expected %h actual %h", want.rad, got.rad); fail_count++;
        end
        if (got.ang != want.ang) begin
          $error("angle_out expected %h actual %h", want.ang, got.ang); fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction or taken result
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("polar_point_transform_unit_core test failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(32'h00040000) - 32'h00020000;
      3: return 32'($urandom_range(32'h0000FFFF));
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_op(OP_ROTATE, 32'h0, 32'h0);             // read at reset: origin
    send_op(OP_SET_CART, 32'h0, 32'h0);           // origin
    send_op(OP_SET_CART, 32'h00030000, 32'h00040000);
    send_op(OP_SET_CART, 32'h80000000, 32'h80000000);
    send_op(OP_SET_CART, 32'h7FFFFFFF, 32'h7FFFFFFF); // radius overflow
    send_op(OP_SET_CART, 32'hFFFF0000, 32'h0);
    send_op(OP_SET_POLAR, 32'hFFFE0000, 32'h20000000); // negative radius
    send_op(OP_SET_POLAR, 32'h7FFFFFFF, 32'hC0000000);
    send_op(OP_OFFSET, 32'h7FFFFFFF, 32'h7FFFFFFF);  // saturating sum
    send_op(OP_SET_POLAR, 32'h00010000, 32'h40000000);
    send_op(OP_OFFSET, 32'h80000000, 32'h80000000);
    send_op(OP_SET_POLAR, 32'h00200000, 32'h10000000);
    send_op(OP_SCALE, 32'h7FFFFFFF, 32'h80000000);  // saturating product
    send_op(OP_SCALE, 32'hFFFF8000, 32'h00008001);
    send_op(OP_ADD_RAD, 32'h7FFFFFFF, 32'h0);       // radius saturation
    send_op(OP_ADD_RAD, 32'h80000000, 32'hFFFFFFFF);
    send_op(OP_ADD_RAD, 32'h80000000, 32'h0);
    send_op(OP_ROTATE, 32'hFFFFFFFF, 32'h12345678);
    send_op(OP_ROTATE, 32'h80000000, 32'h0);
    send_op(OP_READ, 32'h0, 32'hFFFFFFFF);          // read
    send_op(OP_SPARE, 32'hFFFFFFFF, 32'h0);         // unused code reads
  endtask

  task automatic test_random(input int count, input int s_idle, input int r_idle);
    logic [2:0] op;
    logic [31:0] a, b;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int n = 0; n < count; n++) begin
      op = 3'($urandom_range(7));
      a = rand_word();
      b = rand_word();
      // keep most scale factors near unity so the point stays in range
      if (op == OP_SCALE && $urandom_range(3) != 0) begin
        a = 32'h00010000 + $urandom_range(32'h8000) - 32'h4000;
        b = 32'h00010000 + $urandom_range(32'h8000) - 32'h4000;
      end
      send_op(op, a, b);
    end
  endtask

  // Hold the receiver off so the output register fills and input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b1;
    fork
      begin
        for (int c = 0; c < 400; c++) @(negedge clk);
        recv_hold = 1'b0;
      end
      for (int n = 0; n < 6; n++) send_op(3'($urandom_range(7)), rand_word(), rand_word());
    join
  endtask

  initial begin
    int drain;
    pt_radius = 0;
    pt_heading = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(580, 35, 74);
    test_backpressure();
    test_random(580, 74, 35);
    test_random(580, 0, 0);
    recv_idle_pct = 0;
    while (expected_points.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 100) begin
      @(posedge clk);
      drain++;
    end
    if (fail_count == 0) $display("polar_point_transform_unit_core test passed");
    else $display("polar_point_transform_unit_core test failed");
    $finish;
  end
endmodule
